// ===== src/tpp_pkg.sv =====
// shared constants, types and table geometry for the tabulated pair potential
package tpp_pkg;

  // table geometry
  localparam int TABLE_POINTS = 1000;
  localparam int IDX_W        = $clog2(TABLE_POINTS);
  localparam int ADDR_W       = IDX_W + 1;
  localparam int RAM_DEPTH    = 2 ** ADDR_W;
  localparam int SQRT_STEPS   = 32;

  // per-kind start distance (Q16.16) and reciprocal step (Q16.16)
  localparam logic [31:0] RMIN_PHOS = 32'd720896;
  localparam logic [31:0] RMIN_BASE = 32'd406323;
  localparam logic [25:0] INV_PHOS  = 26'd9989695;
  localparam logic [25:0] INV_BASE  = 26'd36372480;

  // weak attraction beyond the table end: q = round(k * 65536 / 1000)
  localparam logic [24:0] SAT_K      = 25'd32768000;
  localparam logic [25:0] RECIP_125  = 26'd34359739;
  localparam logic [23:0] RECIP_1000 = 24'd8589935;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REGION_INTERP = 2'd0,
    REGION_BELOW  = 2'd1,
    REGION_BEYOND = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    CFG_BOX_X   = 2'd0,
    CFG_BOX_Y   = 2'd1,
    CFG_BOX_Z   = 2'd2,
    CFG_NOBREAK = 2'd3
  } cfg_index_t;

  // item fields that travel alongside the arithmetic
  typedef struct packed {
    logic        valid;
    logic        load;
    logic        phos;
    logic [9:0]  entry_index;
    logic [31:0] entry_value;
  } tpp_side_t;

endpackage

// ===== src/tabulated_pair_potential.sv =====
// top level of the tabulated pair potential evaluator
// Takes one transaction per cycle while the output is not stalled: table loads
// and pair evaluations share the input stream and stay in order. An evaluation
// gives one result after passing 5 geometry stages, 32 square-root stages and 7
// lookup and interpolation stages; a load gives no result and writes its table
// entry when it reaches the table addressing stage of the lookup. Tables hold no defined value until loaded.
// The whole pipeline advances whenever the result register is empty or taken,
// so a stalled output holds everything in place and nothing is lost.
module tabulated_pair_potential import tpp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_index, entry_value, first_x, first_y, first_z,
  // second_x, second_y, second_z, zero fill
  input  logic [239:0] in_tdata,
  // opcode, bead_is_phosphate
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // energy
  output logic [31:0]  out_tdata,
  // region
  output logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  logic [2:0][31:0] box_len_r;
  logic             nobreak_r;
  logic             en;
  tpp_side_t        side_in;
  logic [2:0][31:0] first;
  logic [2:0][31:0] second;
  tpp_side_t        side_g;
  logic [63:0]      sumsq;
  logic             big_g;
  tpp_side_t        side_s;
  logic [31:0]      root;
  logic             big_s;
  logic [31:0]      energy;
  region_t          region;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_len_r <= '0;
      nobreak_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_BOX_X:   box_len_r[0] <= cfg_wdata;
        CFG_BOX_Y:   box_len_r[1] <= cfg_wdata;
        CFG_BOX_Z:   box_len_r[2] <= cfg_wdata;
        CFG_NOBREAK: nobreak_r    <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  // pipeline advance
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // unpack the input transaction
  always_comb begin
    side_in.valid       = in_tvalid;
    side_in.load        = (opcode_t'(in_tuser[0]) == OP_LOAD);
    side_in.phos        = in_tuser[1];
    side_in.entry_index = in_tdata[9:0];
    side_in.entry_value = in_tdata[41:10];
    first[0]            = in_tdata[73:42];
    first[1]            = in_tdata[105:74];
    first[2]            = in_tdata[137:106];
    second[0]           = in_tdata[169:138];
    second[1]           = in_tdata[201:170];
    second[2]           = in_tdata[233:202];
  end

  tpp_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .side_i    (side_in),
    .first_i   (first),
    .second_i  (second),
    .box_len_i (box_len_r),
    .side_o    (side_g),
    .sumsq_o   (sumsq),
    .big_o     (big_g)
  );

  tpp_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (side_g),
    .rad_i  (sumsq),
    .big_i  (big_g),
    .side_o (side_s),
    .root_o (root),
    .big_o  (big_s)
  );

  tpp_lookup u_lookup (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .side_i      (side_s),
    .root_i      (root),
    .big_i       (big_s),
    .nobreak_i   (nobreak_r),
    .out_valid_o (out_tvalid),
    .energy_o    (energy),
    .region_o    (region)
  );

  assign out_tdata = energy;
  assign out_tuser = 2'(region);

endmodule

// ===== src/tpp_ram.sv =====
// generic simple dual-port ram with registered read
module tpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tpp_geom.sv =====
// separation, periodic fold, magnitude and sum of squares: five stages
module tpp_geom import tpp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  tpp_side_t        side_i,
  input  logic [2:0][31:0] first_i,
  input  logic [2:0][31:0] second_i,
  input  logic [2:0][31:0] box_len_i,
  output tpp_side_t        side_o,
  output logic [63:0]      sumsq_o,
  output logic             big_o
);

  tpp_side_t        side_r [5];
  logic [2:0][32:0] d1_r;
  logic [2:0][33:0] d2_r;
  logic [2:0][31:0] m3_r;
  logic [2:0][61:0] sq4_r;
  logic             big4_r;
  logic [63:0]      sum5_r;
  logic             big5_r;

  logic [2:0][32:0] diff;
  logic [2:0][33:0] fold;
  logic [2:0][33:0] dx;
  logic [2:0][33:0] half;
  logic [2:0][33:0] len;
  logic [2:0][33:0] mag;
  logic [2:0][31:0] clamp;
  logic [2:0][30:0] ms;
  logic [2:0][61:0] sq;
  logic             big;
  logic [63:0]      sum;

  // per-axis arithmetic of every stage
  always_comb begin
    big = m3_r[0][31] | m3_r[1][31] | m3_r[2][31];
    for (int k = 0; k < 3; k++) begin
      diff[k] = {first_i[k][31], first_i[k]} - {second_i[k][31], second_i[k]};
      dx[k]   = {d1_r[k][32], d1_r[k]};
      half[k] = {3'b000, box_len_i[k][31:1]};
      len[k]  = {2'b00, box_len_i[k]};
      if ($signed(dx[k]) > $signed(half[k])) begin
        fold[k] = dx[k] - len[k];
      end else if ($signed(dx[k]) < -$signed(half[k])) begin
        fold[k] = dx[k] + len[k];
      end else begin
        fold[k] = dx[k];
      end
      mag[k]   = d2_r[k][33] ? (~d2_r[k] + 34'd1) : d2_r[k];
      clamp[k] = (mag[k][33:32] != 2'b00) ? 32'hFFFF_FFFF : mag[k][31:0];
      ms[k]    = big ? m3_r[k][31:1] : m3_r[k][30:0];
      sq[k]    = ms[k] * ms[k];
    end
    sum = {2'b00, sq4_r[0]} + {2'b00, sq4_r[1]} + {2'b00, sq4_r[2]};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 5; s++) begin
        side_r[s].valid <= 1'b0;
      end
    end else if (en) begin
      side_r[0].valid <= side_i.valid;
      for (int s = 1; s < 5; s++) begin
        side_r[s].valid <= side_r[s-1].valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0].load        <= side_i.load;
      side_r[0].phos        <= side_i.phos;
      side_r[0].entry_index <= side_i.entry_index;
      side_r[0].entry_value <= side_i.entry_value;
      for (int s = 1; s < 5; s++) begin
        side_r[s].load        <= side_r[s-1].load;
        side_r[s].phos        <= side_r[s-1].phos;
        side_r[s].entry_index <= side_r[s-1].entry_index;
        side_r[s].entry_value <= side_r[s-1].entry_value;
      end
      d1_r   <= diff;
      d2_r   <= fold;
      m3_r   <= clamp;
      sq4_r  <= sq;
      big4_r <= big;
      sum5_r <= sum;
      big5_r <= big4_r;
    end
  end

  assign side_o  = side_r[4];
  assign sumsq_o = sum5_r;
  assign big_o   = big5_r;

endmodule

// ===== src/tpp_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module tpp_sqrt import tpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  tpp_side_t   side_i,
  input  logic [63:0] rad_i,
  input  logic        big_i,
  output tpp_side_t   side_o,
  output logic [31:0] root_o,
  output logic        big_o
);

  tpp_side_t   side_s [SQRT_STEPS+1];
  logic        big_s  [SQRT_STEPS+1];
  logic [31:0] root_s [SQRT_STEPS+1];
  logic [63:0] rad_s  [SQRT_STEPS];
  logic [33:0] rem_s  [SQRT_STEPS];

  assign side_s[0] = side_i;
  assign big_s[0]  = big_i;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad_i;
  assign rem_s[0]  = '0;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic [35:0] remx;
    logic [35:0] trial;
    logic [33:0] rem_nxt;
    logic [31:0] root_nxt;

    // one restoring digit step
    always_comb begin
      remx  = {rem_s[j], rad_s[j][63:62]};
      trial = remx - {2'b00, root_s[j], 2'b01};
      if (!trial[35]) begin
        rem_nxt  = trial[33:0];
        root_nxt = {root_s[j][30:0], 1'b1};
      end else begin
        rem_nxt  = remx[33:0];
        root_nxt = {root_s[j][30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_s[j+1].valid <= 1'b0;
      end else if (en) begin
        side_s[j+1].valid <= side_s[j].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_s[j+1].load        <= side_s[j].load;
        side_s[j+1].phos        <= side_s[j].phos;
        side_s[j+1].entry_index <= side_s[j].entry_index;
        side_s[j+1].entry_value <= side_s[j].entry_value;
        big_s[j+1]              <= big_s[j];
        root_s[j+1]             <= root_nxt;
      end
    end

    // remainder and radicand are not needed after the last step
    if (j < SQRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[j+1] <= rem_nxt;
          rad_s[j+1] <= {rad_s[j][61:0], 2'b00};
        end
      end
    end
  end

  assign side_o = side_s[SQRT_STEPS];
  assign root_o = root_s[SQRT_STEPS];
  assign big_o  = big_s[SQRT_STEPS];

endmodule

// ===== src/tpp_lookup.sv =====
// table position, table memory, interpolation and tail energy: seven stages
module tpp_lookup import tpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  tpp_side_t   side_i,
  input  logic [31:0] root_i,
  input  logic        big_i,
  input  logic        nobreak_i,
  output logic        out_valid_o,
  output logic [31:0] energy_o,
  output region_t     region_o
);

  // stage 1: distance minus start
  tpp_side_t   side1_r;
  logic        neg1_r;
  logic [33:0] mag1_r;
  logic [32:0] r1;
  logic [31:0] rmin1;
  logic [33:0] diff1;

  always_comb begin
    r1    = big_i ? {root_i, 1'b0} : {1'b0, root_i};
    rmin1 = side_i.phos ? RMIN_PHOS : RMIN_BASE;
    diff1 = {1'b0, r1} - {2'b00, rmin1};
  end

  // stage 2: scale to table position
  tpp_side_t   side2_r;
  logic        neg2_r;
  logic [43:0] pm2_r;
  logic [25:0] inv2;
  logic [59:0] prod2;

  always_comb begin
    inv2  = side1_r.phos ? INV_PHOS : INV_BASE;
    prod2 = mag1_r * inv2;
  end

  // stage 3: classify, address the tables, write loads
  logic                v3_r;
  region_t             region3_r;
  logic signed [16:0]  delta3_r;
  logic                nb3_r;
  logic [27:0]         k3_r;
  logic [27:0]         ipart;
  logic [15:0]         frac;
  region_t             region3;
  logic [IDX_W-1:0]    idx3;
  logic [IDX_W-1:0]    a0;
  logic [IDX_W-1:0]    a1;
  logic signed [16:0]  delta3;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [31:0]         rd0;
  logic [31:0]         rd1;

  always_comb begin
    ipart   = pm2_r[43:16];
    frac    = pm2_r[15:0];
    region3 = REGION_INTERP;
    idx3    = '0;
    delta3  = '0;
    if (!neg2_r) begin
      if (ipart >= 28'(TABLE_POINTS - 1)) begin
        region3 = REGION_BEYOND;
      end else begin
        idx3   = ipart[IDX_W-1:0];
        delta3 = {1'b0, frac};
      end
    end else if (ipart != '0) begin
      region3 = REGION_BELOW;
    end else begin
      delta3 = -$signed({1'b0, frac});
    end
    a0    = (region3 == REGION_BEYOND) ? IDX_W'(TABLE_POINTS - 1) : idx3;
    a1    = idx3 + IDX_W'(1);
    we    = en && side2_r.valid && side2_r.load &&
            (32'(side2_r.entry_index) < TABLE_POINTS);
    waddr = {side2_r.phos, IDX_W'(side2_r.entry_index)};
  end

  // two copies so both neighbours are read in the same cycle
  tpp_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram_lo (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (side2_r.entry_value),
    .re    (en),
    .raddr ({side2_r.phos, a0}),
    .rdata (rd0)
  );

  tpp_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram_hi (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (side2_r.entry_value),
    .re    (en),
    .raddr ({side2_r.phos, a1}),
    .rdata (rd1)
  );

  // stage 4: weighted products; tail split by 125
  logic                v4_r;
  region_t             region4_r;
  logic                nb4_r;
  logic                ksat4_r;
  logic [24:0]         k4_r;
  logic [50:0]         p125_4_r;
  logic signed [49:0]  m0_4_r;
  logic signed [48:0]  m1_4_r;
  logic signed [31:0]  t0_4_r;
  logic signed [17:0]  w0;
  logic signed [49:0]  m0;
  logic signed [48:0]  m1;

  always_comb begin
    w0 = 18'sd65536 - {delta3_r[16], delta3_r};
    m0 = $signed(rd0) * w0;
    m1 = $signed(rd1) * delta3_r;
  end

  // stage 5: rounded sum; tail remainder
  logic                v5_r;
  region_t             region5_r;
  logic                nb5_r;
  logic                ksat5_r;
  logic [17:0]         a5_r;
  logic [22:0]         x5_r;
  logic signed [34:0]  e5_r;
  logic signed [50:0]  acc5;
  logic [17:0]         a5;
  logic [24:0]         b5;

  always_comb begin
    acc5 = {m0_4_r[49], m0_4_r} + {{2{m1_4_r[48]}}, m1_4_r} + 51'sd32768;
    a5   = p125_4_r[49:32];
    b5   = k4_r - 25'(a5 * 8'd125);
  end

  // stage 6: saturation; tail divide by 1000
  logic                v6_r;
  region_t             region6_r;
  logic                nb6_r;
  logic                ksat6_r;
  logic [17:0]         a6_r;
  logic [46:0]         px6_r;
  logic [31:0]         e6_r;
  logic [31:0]         e6;

  always_comb begin
    if (e5_r > 35'sd2147483647) begin
      e6 = 32'h7FFF_FFFF;
    end else if (e5_r < -35'sd2147483648) begin
      e6 = 32'h8000_0000;
    end else begin
      e6 = e5_r[31:0];
    end
  end

  // stage 7: result register
  logic        out_valid_r;
  logic [31:0] energy_r;
  region_t     region_r;
  logic [30:0] q7;

  assign q7 = {a6_r, 13'b0} + {18'b0, px6_r[45:33]};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.valid <= 1'b0;
      side2_r.valid <= 1'b0;
      v3_r          <= 1'b0;
      v4_r          <= 1'b0;
      v5_r          <= 1'b0;
      v6_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (en) begin
      side1_r.valid <= side_i.valid;
      side2_r.valid <= side1_r.valid;
      v3_r          <= side2_r.valid && !side2_r.load;
      v4_r          <= v3_r;
      v5_r          <= v4_r;
      v6_r          <= v5_r;
      out_valid_r   <= v6_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      side1_r.load        <= side_i.load;
      side1_r.phos        <= side_i.phos;
      side1_r.entry_index <= side_i.entry_index;
      side1_r.entry_value <= side_i.entry_value;
      neg1_r              <= diff1[33];
      mag1_r              <= diff1[33] ? (~diff1 + 34'd1) : diff1;

      side2_r.load        <= side1_r.load;
      side2_r.phos        <= side1_r.phos;
      side2_r.entry_index <= side1_r.entry_index;
      side2_r.entry_value <= side1_r.entry_value;
      neg2_r              <= neg1_r;
      pm2_r               <= prod2[59:16];

      region3_r <= region3;
      delta3_r  <= delta3;
      nb3_r     <= nobreak_i && !side2_r.phos && (region3 == REGION_BEYOND);
      k3_r      <= ipart - 28'(TABLE_POINTS - 1);

      region4_r <= region3_r;
      nb4_r     <= nb3_r;
      ksat4_r   <= k3_r >= {3'b000, SAT_K};
      k4_r      <= k3_r[24:0];
      p125_4_r  <= k3_r[24:0] * RECIP_125;
      m0_4_r    <= m0;
      m1_4_r    <= m1;
      t0_4_r    <= $signed(rd0);

      region5_r <= region4_r;
      nb5_r     <= nb4_r;
      ksat5_r   <= ksat4_r;
      a5_r      <= a5;
      x5_r      <= {b5[6:0], 16'b0} + 23'd500;
      e5_r      <= (region4_r == REGION_INTERP) ? acc5[50:16]
                                                : {{3{t0_4_r[31]}}, t0_4_r};

      region6_r <= region5_r;
      nb6_r     <= nb5_r;
      ksat6_r   <= ksat5_r;
      a6_r      <= a5_r;
      px6_r     <= x5_r * RECIP_1000;
      e6_r      <= e6;

      region_r  <= region6_r;
      if (nb6_r) begin
        energy_r <= ksat6_r ? 32'h7FFF_FFFF : {1'b0, q7};
      end else begin
        energy_r <= e6_r;
      end
    end
  end

  assign out_valid_o = out_valid_r;
  assign energy_o    = energy_r;
  assign region_o    = region_r;

endmodule

// ===== verif/tb_tabulated_pair_potential.sv =====
// self-checking testbench for the tabulated pair potential evaluator
module tb_tabulated_pair_potential;
  import tpp_pkg::*;

  localparam int          LAST_ENTRY  = TABLE_POINTS - 1;
  localparam int          DRAIN_WAIT  = 60;
  localparam int          CYCLE_LIMIT = 300000;
  localparam logic [31:0] UNIT        = 32'd65536;

  typedef struct {
    opcode_t            op;
    logic               phos;
    logic [9:0]         idx;
    logic [31:0]        val;
    logic signed [31:0] fx, fy, fz, sx, sy, sz;
  } pair_item_t;

  typedef struct {
    logic [31:0] energy;
    region_t     region;
  } energy_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [239:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;

  // local copy of block state
  logic signed [31:0] phos_energy [TABLE_POINTS];
  logic signed [31:0] base_energy [TABLE_POINTS];
  logic [31:0]        box_x, box_y, box_z;
  logic               nobreak;

  pair_item_t     pending_items [$];
  energy_result_t expected_energies [$];
  int             errors = 0;
  int             accepted = 0;
  int             in_gap = 0;
  int             out_gap = 0;
  int             hold_left = 0;
  bit             hold_go = 0;
  bit             hold_done = 0;
  bit             calm = 0;
  int unsigned    cycles = 0;

  tabulated_pair_potential dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // minimum-image magnitude along one axis, clamped to 32 bits
  function automatic longint unsigned axis_mag(logic signed [31:0] a, logic signed [31:0] b,
                                                logic [31:0] len);
    longint d;
    longint h;
    d = longint'(a) - longint'(b);
    h = longint'(len >> 1);
    if (d > h) d -= longint'(len);
    else if (d < -h) d += longint'(len);
    if (d < 0) d = -d;
    return (d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : longint'(d);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // energy and region of one bead pair
  function automatic energy_result_t pair_energy(pair_item_t it);
    energy_result_t  res;
    longint unsigned mx, my, mz, r, mag, pm, q;
    longint          diff, idx, delta, e, acc;
    logic signed [31:0] lo, hi;
    mx = axis_mag(it.fx, it.sx, box_x);
    my = axis_mag(it.fy, it.sy, box_y);
    mz = axis_mag(it.fz, it.sz, box_z);
    if (mx[31] || my[31] || mz[31]) begin
      mx >>= 1; my >>= 1; mz >>= 1;
      r = floor_sqrt(mx * mx + my * my + mz * mz) << 1;
    end else begin
      r = floor_sqrt(mx * mx + my * my + mz * mz);
    end
    diff = longint'(r) - longint'(it.phos ? RMIN_PHOS : RMIN_BASE);
    mag = (diff < 0) ? -diff : diff;
    pm = (mag * longint'(it.phos ? INV_PHOS : INV_BASE)) >> 16;
    idx = longint'(pm >> 16);
    delta = longint'(pm & 64'hFFFF);
    if (diff < 0) begin
      idx = -idx;
      delta = -delta;
    end
    if (idx >= LAST_ENTRY) begin
      res.region = REGION_BEYOND;
      if (nobreak && !it.phos) begin
        q = (longint'(idx - LAST_ENTRY) * 65536 + 500) / 1000;
        e = (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(q);
      end else begin
        e = it.phos ? phos_energy[LAST_ENTRY] : base_energy[LAST_ENTRY];
      end
    end else if (idx < 0) begin
      res.region = REGION_BELOW;
      e = it.phos ? phos_energy[0] : base_energy[0];
    end else begin
      lo = it.phos ? phos_energy[idx] : base_energy[idx];
      hi = it.phos ? phos_energy[idx + 1] : base_energy[idx + 1];
      acc = longint'(lo) * (65536 - delta) + longint'(hi) * delta + 32768;
      res.region = REGION_INTERP;
      e = acc >>> 16;
    end
    if (e > 64'sh7FFF_FFFF) e = 64'sh7FFF_FFFF;
    else if (e < -64'sh8000_0000) e = -64'sh8000_0000;
    res.energy = e[31:0];
    return res;
  endfunction

  // apply one accepted transaction to the local state
  function automatic void absorb(pair_item_t it);
    if (it.op == OP_LOAD) begin
      if (it.idx < TABLE_POINTS) begin
        if (it.phos) phos_energy[it.idx] = it.val;
        else base_energy[it.idx] = it.val;
      end
    end else begin
      expected_energies.push_back(pair_energy(it));
    end
  endfunction

  function automatic void add_load(logic phos, logic [9:0] idx, logic [31:0] val);
    pair_item_t it;
    it = '{op: OP_LOAD, phos: phos, idx: idx, val: val,
           fx: $urandom, fy: $urandom, fz: $urandom, sx: $urandom, sy: $urandom, sz: $urandom};
    pending_items.push_back(it);
  endfunction

  function automatic void add_eval(logic phos, logic signed [31:0] fx, logic signed [31:0] fy,
                                   logic signed [31:0] fz, logic signed [31:0] dx,
                                   logic signed [31:0] dy, logic signed [31:0] dz);
    pair_item_t it;
    it = '{op: OP_EVAL, phos: phos, idx: $urandom, val: $urandom,
           fx: fx, fy: fy, fz: fz, sx: fx - dx, sy: fy - dy, sz: fz - dz};
    pending_items.push_back(it);
  endfunction

  function automatic logic signed [31:0] near_coord(int unsigned span);
    return $signed($urandom_range(0, 2 * span)) - $signed(span);
  endfunction

  // mostly pairs at table distances, the rest arbitrary positions and loads
  function automatic void add_random(int n);
    int unsigned kind;
    logic        phos;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      phos = $urandom_range(0, 1);
      if (kind == 0) begin
        add_load(phos, $urandom_range(0, 1023), $urandom);
      end else if (kind == 1) begin
        add_eval(phos, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        add_eval(phos, near_coord(32'h4000_0000), near_coord(32'h4000_0000),
                 near_coord(32'h4000_0000), near_coord((phos ? 20 : 10) * UNIT),
                 near_coord(3 * UNIT), near_coord(3 * UNIT));
      end
    end
  endfunction

  task automatic write_reg(input cfg_index_t i, input logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= i;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (i)
      CFG_BOX_X:   box_x = v;
      CFG_BOX_Y:   box_y = v;
      CFG_BOX_Z:   box_z = v;
      CFG_NOBREAK: nobreak = v[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] bx, input logic [31:0] by,
                           input logic [31:0] bz, input logic nb);
    write_reg(CFG_BOX_X, bx);
    write_reg(CFG_BOX_Y, by);
    write_reg(CFG_BOX_Z, bz);
    write_reg(CFG_NOBREAK, {31'b0, nb});
  endtask

  task automatic drain;
    while (pending_items.size() != 0 || expected_energies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb(pending_items.pop_front());
        accepted++;
      end
      if (in_tvalid && !in_tready) begin
        in_tvalid <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 3);
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tuser  <= {pending_items[0].phos, pending_items[0].op};
        in_tdata  <= {6'b0, pending_items[0].sz, pending_items[0].sy, pending_items[0].sx,
                      pending_items[0].fz, pending_items[0].fy, pending_items[0].fx,
                      pending_items[0].val, pending_items[0].idx};
      end
    end
  end

  // result receiver readiness, with one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    energy_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_energies.size() == 0) begin
        report($sformatf("unexpected result energy %h region %0d", out_tdata, out_tuser));
      end else begin
        want = expected_energies.pop_front();
        if (out_tdata !== want.energy)
          report($sformatf("energy %h, wanted %h", out_tdata, want.energy));
        if (out_tuser !== want.region)
          report($sformatf("region %0d, wanted %0d", out_tuser, want.region));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    box_x = '0;
    box_y = '0;
    box_z = '0;
    nobreak = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // fill both tables so no unwritten entry is ever read
    configure(32'd0, 32'd0, 32'd0, 1'b0);
    for (int k = 0; k < TABLE_POINTS; k++) begin
      add_load(1'b1, k, (k == 0) ? 32'h7FFF_FFFF : (k == 1) ? 32'h8000_0000 : $urandom);
      add_load(1'b0, k, (k == LAST_ENTRY) ? 32'h8000_0000 : $urandom);
    end
    // out-of-range loads are dropped
    add_load(1'b1, 10'd1000, 32'h1234_5678);
    add_load(1'b0, 10'd1023, 32'hDEAD_BEEF);
    // coincident beads, table start, just below it, far beyond, extreme coordinates
    add_eval(1'b1, 0, 0, 0, 0, 0, 0);
    add_eval(1'b0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    add_eval(1'b1, 5, 6, 7, RMIN_PHOS, 0, 0);
    add_eval(1'b0, 5, 6, 7, 0, 0, RMIN_BASE);
    add_eval(1'b1, 0, 0, 0, RMIN_PHOS - 32'd100, 0, 0);
    add_eval(1'b0, 0, 0, 0, 0, RMIN_BASE - 32'd50, 0);
    add_eval(1'b1, 0, 0, 0, 30 * UNIT, 0, 0);
    add_eval(1'b0, 0, 0, 0, 9 * UNIT, 0, 0);
    add_eval(1'b1, 0, 0, 0, 32'sd13 * UNIT, 32'sd1 * UNIT, 0);
    add_eval(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_eval(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    pending_items.push_back(pending_items[$]);
    pending_items[$].fx = 32'h8000_0000;
    pending_items[$].sx = 32'h7FFF_FFFF;
    drain();

    // no-break bases, including the edge of the table
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_eval(1'b0, 0, 0, 0, 9 * UNIT, 0, 0);
    add_eval(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_eval(1'b1, 0, 0, 0, 30 * UNIT, 0, 0);
    hold_go = 1;
    add_random(150);
    drain();

    configure(20 * UNIT, 17 * UNIT + 32'd12345, 23 * UNIT, 1'b1);
    add_random(140);
    drain();

    configure(32'd1, 30 * UNIT, $urandom, 1'b0);
    add_random(130);
    drain();

    calm = 1;
    configure(0, 0, 0, 1'b0);
    add_random(130);
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
